// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; the caller supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the next cycle, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked in the same cycle, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/toeq_pkg.sv =====
// Package for the time-ordered event queue: sizes, entry type, mode codes,
// cell control type and key compare. Depends on nothing; used by the cell, top-level and checker files.
package toeq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PAY_W  = 16;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef struct packed {
    logic [TIME_W-1:0] evt_time;
    logic              is_dep;
    logic [PAY_W-1:0]  payload;
  } entry_t;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

  // True when a stored entry orders strictly after the new key.
  function automatic logic key_after(entry_t stored, entry_t incoming);
    logic res;
    if (stored.evt_time != incoming.evt_time) begin
      res = (stored.evt_time > incoming.evt_time);
    end else begin
      res = stored.is_dep & ~incoming.is_dep;
    end
    return res;
  endfunction

endpackage

// ===== rtl/toeq_cell.sv =====
// One slot of the sorted shift chain: holds an entry and its valid bit.
// Depends on toeq_pkg for the entry type and the key compare.
module toeq_cell import toeq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_entry_i,
  input  entry_t     left_entry_i,
  input  logic       left_valid_i,
  input  logic       left_after_i,
  input  entry_t     right_entry_i,
  input  logic       right_valid_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       after_o
);

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;

  // An empty slot counts as ordering after any key, so the new item lands
  // in the first slot that orders after it, the one whose left neighbor does not.
  assign after_o = ~valid_q | key_after(entry_q, new_entry_i);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.enq) begin
      if (after_o) begin
        entry_d = left_after_i ? left_entry_i : new_entry_i;
        valid_d = valid_q | left_valid_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_entry_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/time_ordered_event_queue_top.sv =====
// The result of an item shows in the cycle after it is accepted.
// Throughput: one item per cycle; busy_o stays low, since every cell
// compares against the broadcast key and shifts in the same cycle.
// Reset clears all valid bits (queue empty) and the result strobe;
// the receiver cannot stall, so no result is ever held back.
module time_ordered_event_queue_top import toeq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [TIME_W-1:0] event_time_i,
  input  logic              is_departure_i,
  input  logic [PAY_W-1:0]  event_payload_i,
  output logic              valid_o,
  output logic              done_res_o,
  output logic              now_empty_o,
  output logic              now_full_o,
  output logic [TIME_W-1:0] front_time_o,
  output logic              front_is_departure_o,
  output logic [PAY_W-1:0]  front_payload_o
);

  entry_t     new_entry;
  entry_t     cell_entry [DEPTH];
  logic       cell_valid [DEPTH];
  logic       cell_after [DEPTH];
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full, empty;
  logic       valid_q, done_q, done_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign full   = cell_valid[DEPTH-1];
  assign empty  = ~cell_valid[0];

  assign new_entry.evt_time = event_time_i;
  assign new_entry.is_dep   = is_departure_i;
  assign new_entry.payload  = event_payload_i;

  always_comb begin
    ctrl.enq = accept & (mode_i == MODE_ENQ) & ~full;
    ctrl.deq = accept & (mode_i == MODE_DEQ) & ~empty;
    done_d   = ctrl.enq | ctrl.deq;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_valid, left_after, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_valid = 1'b1;
      assign left_after = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_after = cell_after[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    toeq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .left_valid_i  (left_valid),
      .left_after_i  (left_after),
      .right_entry_i (right_entry),
      .right_valid_i (right_valid),
      .entry_o       (cell_entry[i]),
      .valid_o       (cell_valid[i]),
      .after_o       (cell_after[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
  end

  // The flags and front fields read the chain as it stands after the item.
  assign valid_o              = valid_q;
  assign done_res_o           = done_q;
  assign now_empty_o          = empty;
  assign now_full_o           = full;
  assign front_time_o         = empty ? '0 : cell_entry[0].evt_time;
  assign front_is_departure_o = empty ? 1'b0 : cell_entry[0].is_dep;
  assign front_payload_o      = empty ? '0 : cell_entry[0].payload;

endmodule

// ===== rtl/toeq_checker.sv =====
// Port-level checker for the event queue, bound to the top level.
// Depends on toeq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module toeq_checker import toeq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              mode_i,
  input logic              valid_o,
  input logic              done_res_o,
  input logic              now_empty_o,
  input logic              now_full_o,
  input logic [TIME_W-1:0] front_time_o,
  input logic              front_is_departure_o,
  input logic [PAY_W-1:0]  front_payload_o
);

  // Every accepted item gives exactly one result in the next cycle.
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, start_i && !busy_o, valid_o)
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !(start_i && !busy_o), !valid_o)
  // A queue of at least two slots is never both empty and full.
  `ASSERT_SAME(a_flags_excl, clk_i, rst_ni, valid_o, !(now_empty_o && now_full_o))
  // An empty queue shows an all-zero front item.
  `ASSERT_SAME(a_empty_front, clk_i, rst_ni, valid_o && now_empty_o,
    front_time_o == '0 && !front_is_departure_o && front_payload_o == '0)
  // A removal that succeeds never leaves the queue full.
  `ASSERT_NEXT(a_deq_not_full, clk_i, rst_ni,
    start_i && !busy_o && mode_i == MODE_DEQ, !(done_res_o && now_full_o))

endmodule

bind time_ordered_event_queue_top toeq_checker u_toeq_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start_i              (start_i),
  .busy_o               (busy_o),
  .mode_i               (mode_i),
  .valid_o              (valid_o),
  .done_res_o           (done_res_o),
  .now_empty_o          (now_empty_o),
  .now_full_o           (now_full_o),
  .front_time_o         (front_time_o),
  .front_is_departure_o (front_is_departure_o),
  .front_payload_o      (front_payload_o)
);
